// ===== src/mini_c_lexer_token_classifier_top_assert.svh =====
// assertion macros for the mini c token classifier
// used by mini_c_lexer_token_classifier_top; expects clk and rst_n in scope
`ifndef MINI_C_LEXER_TOKEN_CLASSIFIER_TOP_ASSERT_SVH
`define MINI_C_LEXER_TOKEN_CLASSIFIER_TOP_ASSERT_SVH

// same-cycle implication
`define MCLEX_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mclex: same-cycle check failed");

// next-cycle implication
`define MCLEX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mclex: next-cycle check failed");

`endif

// ===== src/mclex_pkg.sv =====
// shared types, constants and helper functions for the mini c token classifier
// no dependencies
package mclex_pkg;

  localparam int WORD_LEN_W = 8;
  localparam logic [WORD_LEN_W-1:0] MAX_TOKEN_LENGTH = 8'd255;

  localparam logic [2:0] KIND_KEYWORD = 3'd0;
  localparam logic [2:0] KIND_IDENT   = 3'd1;
  localparam logic [2:0] KIND_NUMBER  = 3'd2;
  localparam logic [2:0] KIND_OPER    = 3'd3;
  localparam logic [2:0] KIND_SYMBOL  = 3'd4;

  localparam logic [1:0] KW_INT   = 2'd0;
  localparam logic [1:0] KW_FLOAT = 2'd1;
  localparam logic [1:0] KW_WHILE = 2'd2;
  localparam logic [1:0] KW_MAIN  = 2'd3;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic [7:0]            token_length;
    logic [7:0]            second_char;
    logic [7:0]            first_char;
    logic [1:0]            keyword_index;
    logic [2:0]            token_kind;
  } token_t;

  // up to three tokens caused by one input beat
  typedef struct packed {
    logic [1:0]            cnt;
    token_t [2:0]          tok;
  } bundle_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_operator(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == 8'h2A) || (c == 8'h2F) ||
           (c == 8'h3D) || (c == 8'h3C) || (c == 8'h3E);
  endfunction

  function automatic logic is_symbol(input logic [7:0] c);
    return (c == 8'h28) || (c == 8'h29) || (c == 8'h7B) || (c == 8'h7D) ||
           (c == 8'h3B);
  endfunction

  function automatic logic [WORD_LEN_W-1:0] kw_len(input logic [1:0] k);
    logic [WORD_LEN_W-1:0] l;
    case (k)
      KW_INT:   l = 8'd3;
      KW_FLOAT: l = 8'd5;
      KW_WHILE: l = 8'd5;
      KW_MAIN:  l = 8'd4;
      default:  l = 8'd0;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    case (k)
      KW_INT: begin
        case (pos)
          3'd0: ch = "i";
          3'd1: ch = "n";
          3'd2: ch = "t";
          default: ch = 8'h00;
        endcase
      end
      KW_FLOAT: begin
        case (pos)
          3'd0: ch = "f";
          3'd1: ch = "l";
          3'd2: ch = "o";
          3'd3: ch = "a";
          3'd4: ch = "t";
          default: ch = 8'h00;
        endcase
      end
      KW_WHILE: begin
        case (pos)
          3'd0: ch = "w";
          3'd1: ch = "h";
          3'd2: ch = "i";
          3'd3: ch = "l";
          3'd4: ch = "e";
          default: ch = 8'h00;
        endcase
      end
      KW_MAIN: begin
        case (pos)
          3'd0: ch = "m";
          3'd1: ch = "a";
          3'd2: ch = "i";
          3'd3: ch = "n";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic token_t word_token(input logic [WORD_LEN_W-1:0] len,
                                        input logic [3:0] mask,
                                        input logic num_ok);
    token_t t;
    t = '0;
    t.token_kind   = num_ok ? KIND_NUMBER : KIND_IDENT;
    t.token_length = len;
    for (int k = 3; k >= 0; k--) begin
      if (mask[k] && (len == kw_len(2'(k)))) begin
        t.token_kind    = KIND_KEYWORD;
        t.keyword_index = 2'(k);
      end
    end
    return t;
  endfunction

  function automatic token_t char_token(input logic [2:0] kind, input logic [7:0] c1,
                                        input logic [7:0] c2,
                                        input logic [WORD_LEN_W-1:0] len);
    token_t t;
    t = '0;
    t.token_kind   = kind;
    t.first_char   = c1;
    t.second_char  = c2;
    t.token_length = len;
    return t;
  endfunction

endpackage

// ===== src/mclex_front.sv =====
// front end: takes one source byte per beat, tracks the open word and the
// held operator, and builds the bundle of tokens the byte causes; uses mclex_pkg
module mclex_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc,
  input  logic [7:0]           char_code,
  input  logic                 end_of_input,
  output mclex_pkg::bundle_t   bundle
);

  logic [mclex_pkg::WORD_LEN_W-1:0] len_r, len_nxt, len_app;
  logic                             num_r, num_nxt, num_app;
  logic                             dot_r, dot_nxt, dot_app;
  logic [3:0]                       mask_r, mask_nxt, mask_app;
  logic                             pend_r, pend_nxt;
  logic [7:0]                       pchar_r, pchar_nxt;

  logic pair, sp, op, sy, ending, app;
  logic [1:0] cnt;
  mclex_pkg::bundle_t b;

  always_comb begin
    pair = pend_r && ((pchar_r == mclex_pkg::CH_PLUS) || (pchar_r == mclex_pkg::CH_MINUS))
           && (char_code == pchar_r);
    sp = mclex_pkg::is_space(char_code);
    op = mclex_pkg::is_operator(char_code);
    sy = mclex_pkg::is_symbol(char_code);
    ending = !pair && (sp || op || sy);
    app = !pair && !sp && !op && !sy;

    // word state after appending this byte
    mask_app = mask_r;
    for (int k = 0; k < 4; k++) begin
      if ((len_r >= mclex_pkg::kw_len(2'(k))) ||
          (mclex_pkg::kw_char(2'(k), len_r[2:0]) != char_code))
        mask_app[k] = 1'b0;
    end
    dot_app = dot_r;
    num_app = num_r;
    if ((char_code >= "0") && (char_code <= "9")) begin
      num_app = num_r;
    end else if ((char_code == mclex_pkg::CH_DOT) && !dot_r) begin
      dot_app = 1'b1;
    end else begin
      num_app = 1'b0;
    end
    len_app = (len_r < mclex_pkg::MAX_TOKEN_LENGTH) ? len_r + 8'd1 : len_r;

    // token bundle in emission order
    b = '0;
    cnt = 2'd0;
    if (pend_r) begin
      b.tok[cnt] = pair ?
        mclex_pkg::char_token(mclex_pkg::KIND_OPER, pchar_r, char_code, 8'd2) :
        mclex_pkg::char_token(mclex_pkg::KIND_OPER, pchar_r, 8'd0, 8'd1);
      cnt = cnt + 2'd1;
    end
    if (ending && (len_r != '0)) begin
      b.tok[cnt] = mclex_pkg::word_token(len_r, mask_r, num_r);
      cnt = cnt + 2'd1;
    end
    if (!pair && sy) begin
      b.tok[cnt] = mclex_pkg::char_token(mclex_pkg::KIND_SYMBOL, char_code, 8'd0, 8'd1);
      cnt = cnt + 2'd1;
    end
    if (app && end_of_input) begin
      b.tok[cnt] = mclex_pkg::word_token(len_app, mask_app, num_app);
      cnt = cnt + 2'd1;
    end
    if (!pair && op && end_of_input) begin
      b.tok[cnt] = mclex_pkg::char_token(mclex_pkg::KIND_OPER, char_code, 8'd0, 8'd1);
      cnt = cnt + 2'd1;
    end
    b.cnt = cnt;

    // next state
    len_nxt  = len_r;
    num_nxt  = num_r;
    dot_nxt  = dot_r;
    mask_nxt = mask_r;
    if (ending || (app && end_of_input)) begin
      len_nxt  = '0;
      num_nxt  = 1'b1;
      dot_nxt  = 1'b0;
      mask_nxt = 4'hF;
    end else if (app) begin
      len_nxt  = len_app;
      num_nxt  = num_app;
      dot_nxt  = dot_app;
      mask_nxt = mask_app;
    end
    pend_nxt  = !pair && op && !end_of_input;
    pchar_nxt = pend_nxt ? char_code : 8'd0;
  end

  assign bundle = b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      num_r   <= 1'b1;
      dot_r   <= 1'b0;
      mask_r  <= 4'hF;
      pend_r  <= 1'b0;
      pchar_r <= 8'd0;
    end else if (acc) begin
      len_r   <= len_nxt;
      num_r   <= num_nxt;
      dot_r   <= dot_nxt;
      mask_r  <= mask_nxt;
      pend_r  <= pend_nxt;
      pchar_r <= pchar_nxt;
    end
  end

endmodule

// ===== src/mclex_fifo.sv =====
// short bundle queue between the front end and the token serializer
// uses mclex_pkg for the bundle type and depth
module mclex_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  mclex_pkg::bundle_t   push_data,
  input  logic                 pop,
  output mclex_pkg::bundle_t   head,
  output logic                 full,
  output logic                 empty
);

  mclex_pkg::bundle_t              mem [mclex_pkg::QDEPTH];
  logic [mclex_pkg::QPTR_W-1:0]    wr_r, rd_r;
  logic [mclex_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;

  assign full  = (cnt_r == mclex_pkg::QCNT_W'(mclex_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop) rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== src/mclex_back.sv =====
// back end: walks the head bundle one token per beat into the output register
// uses mclex_pkg for the bundle and token types
module mclex_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mclex_pkg::bundle_t   head,
  input  logic                 head_valid,
  output logic                 pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output mclex_pkg::token_t    out_tok,
  output logic                 out_last
);

  logic [1:0]          idx_r, idx_nxt;
  logic                vld_r, vld_nxt;
  mclex_pkg::token_t   tok_r;
  logic                last_r;
  logic                load, take, at_end;

  always_comb begin
    load    = !vld_r || out_tready;
    take    = head_valid && load;
    at_end  = (idx_r == (head.cnt - 2'd1));
    pop     = take && at_end;
    idx_nxt = idx_r;
    if (take) idx_nxt = at_end ? 2'd0 : idx_r + 2'd1;
    vld_nxt = load ? head_valid : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tok_r  <= head.tok[idx_r];
      last_r <= at_end;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tok    = tok_r;
  assign out_last   = last_r;

endmodule

// ===== src/mini_c_lexer_token_classifier_top.sv =====
// mini c token classifier: source bytes in, classified tokens out
// uses mclex_pkg, mclex_front, mclex_fifo, mclex_back and the assert header
//
// input stream: one source byte per beat on in_tdata, in_tlast on the final
// byte of the text; pending word and held operator flush after that byte.
// output stream: one token per beat, token kind on out_tuser, the rest on
// out_tdata; out_tlast marks the last token a given input byte caused.
// a byte causes zero to three tokens.
// path: the tokens a byte causes enter the queue as one bundle when the byte is
// accepted; the back end then loads the first into the register behind out_tdata.
// throughput: one byte per cycle while out_tready is high and each byte causes at
// most one token; the token register drains one token per cycle while out_tready
// is high, so a byte causing more tokens holds the back end until all are taken.
// a four-entry bundle queue absorbs bursts. in_tready drops only while it is full.
// stall: when out_tready is low the token register holds, the queue fills,
// and then in_tready falls; nothing is lost or repeated.
// reset: rst_n low clears word tracking, the held operator, the queue and the
// output valid; the block is ready as soon as reset is released.
`include "mini_c_lexer_token_classifier_top_assert.svh"
module mini_c_lexer_token_classifier_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_code[7:0]
  input  logic        in_tlast,   // end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // keyword_index[1:0], first_char[9:2], second_char[17:10],
                                  // token_length[25:18], zero[31:26]
  output logic [2:0]  out_tuser,  // token_kind[2:0]
  output logic        out_tlast   // last_of_run
);

  mclex_pkg::bundle_t front_bundle, q_head;
  mclex_pkg::token_t  tok;
  logic               acc, push, pop, q_full, q_empty;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;
  assign push      = acc && (front_bundle.cnt != 2'd0);

  mclex_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (acc),
    .char_code    (in_tdata),
    .end_of_input (in_tlast),
    .bundle       (front_bundle)
  );

  mclex_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_bundle),
    .pop       (pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  mclex_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (!q_empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tok    (tok),
    .out_last   (out_tlast)
  );

  assign out_tdata = {6'b000000, tok.token_length, tok.second_char, tok.first_char,
                      tok.keyword_index};
  assign out_tuser = tok.token_kind;

  `MCLEX_ASSERT_NOW(a_push_count, push, (front_bundle.cnt != 2'd0))
  `MCLEX_ASSERT_NOW(a_full_blocks, q_full, !in_tready)
  `MCLEX_ASSERT_NEXT(a_pop_last, pop, (out_tvalid && out_tlast))

endmodule

// ===== sim/testbench.sv =====
// testbench for mini_c_lexer_token_classifier_top: directed byte table, then random source text
// every token beat is checked against the lexer model or a typed row; needs mclex_pkg, top level
`timescale 1ns / 100ps
module testbench;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_BYTES  = 185;
  localparam int HOLD_CYCLES   = 90;

  typedef struct packed {
    logic       last;
    logic [7:0] len;
    logic [7:0] c2;
    logic [7:0] c1;
    logic [1:0] kwi;
    logic [2:0] kind;
  } token_beat_t;

  typedef struct packed {
    logic [7:0]  code;
    logic        eoi;
    logic        typed;
    token_beat_t tok;
  } stim_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  mini_c_lexer_token_classifier_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  string       kw_words [4] = '{"int", "float", "while", "main"};
  int          kw_size  [4] = '{3, 5, 5, 4};
  string       ws_chars = " \t\n\v\f\r";
  string       op_chars = "+-*/=<>";
  string       sym_chars = "(){};";

  // lexer model state
  logic [7:0]  wlen = 8'd0;
  logic        num_ok = 1'b1;
  logic        dot_seen = 1'b0;
  logic [3:0]  kw_mask = 4'hF;
  logic        op_held = 1'b0;
  logic [7:0]  op_char = 8'h00;

  token_beat_t byte_toks [$];
  token_beat_t token_q [$];
  stim_row_t   directed_rows [$];
  logic [7:0]  piece [$];
  logic        piece_eoi;

  int          errors = 0;
  logic        calm = 1'b0;
  logic        rx_hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic blank_char(input logic [7:0] c);
    case (c)
      " ", "\t", "\n", "\v", "\f", "\r": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic op_byte(input logic [7:0] c);
    case (c)
      "+", "-", "*", "/", "=", "<", ">": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic sym_byte(input logic [7:0] c);
    case (c)
      "(", ")", "{", "}", ";": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic token_beat_t char_tok(input logic [2:0] kind, input logic [7:0] c1,
                                           input logic [7:0] c2, input logic [7:0] len);
    token_beat_t t;
    t = '0;
    t.kind = kind;
    t.c1   = c1;
    t.c2   = c2;
    t.len  = len;
    return t;
  endfunction

  task automatic close_word();
    token_beat_t t;
    logic        found;
    if (wlen != 8'd0) begin
      t = '0;
      t.len = wlen;
      found = 1'b0;
      for (int k = 0; k < 4; k++) begin
        if (!found && kw_mask[k] && wlen == kw_size[k]) begin
          found  = 1'b1;
          t.kind = mclex_pkg::KIND_KEYWORD;
          t.kwi  = k[1:0];
        end
      end
      if (!found) t.kind = num_ok ? mclex_pkg::KIND_NUMBER : mclex_pkg::KIND_IDENT;
      byte_toks.insert(byte_toks.size(), t);
      wlen     = 8'd0;
      num_ok   = 1'b1;
      dot_seen = 1'b0;
      kw_mask  = 4'hF;
    end
  endtask

  task automatic grow_word(input logic [7:0] c);
    for (int k = 0; k < 4; k++) begin
      if (wlen >= kw_size[k]) kw_mask[k] = 1'b0;
      else if (kw_words[k][wlen] != c) kw_mask[k] = 1'b0;
    end
    if (c >= "0" && c <= "9") begin
      // digits keep a number a number
    end else if (c == mclex_pkg::CH_DOT && !dot_seen) begin
      dot_seen = 1'b1;
    end else begin
      num_ok = 1'b0;
    end
    if (wlen < mclex_pkg::MAX_TOKEN_LENGTH) wlen = wlen + 8'd1;
  endtask

  // tokens caused by one accepted byte land in byte_toks
  task automatic lex_byte(input logic [7:0] c, input logic eoi);
    logic paired;
    byte_toks.delete();
    paired = 1'b0;
    if (op_held) begin
      if ((op_char == mclex_pkg::CH_PLUS || op_char == mclex_pkg::CH_MINUS) && c == op_char) begin
        byte_toks.insert(byte_toks.size(), char_tok(mclex_pkg::KIND_OPER, op_char, c, 8'd2));
        paired = 1'b1;
      end else begin
        byte_toks.insert(byte_toks.size(),
                         char_tok(mclex_pkg::KIND_OPER, op_char, 8'h00, 8'd1));
      end
      op_held = 1'b0;
      op_char = 8'h00;
    end
    if (!paired) begin
      if (blank_char(c)) begin
        close_word();
      end else if (op_byte(c)) begin
        close_word();
        op_held = 1'b1;
        op_char = c;
      end else if (sym_byte(c)) begin
        close_word();
        byte_toks.insert(byte_toks.size(), char_tok(mclex_pkg::KIND_SYMBOL, c, 8'h00, 8'd1));
      end else begin
        grow_word(c);
      end
    end
    if (eoi) begin
      close_word();
      if (op_held) begin
        byte_toks.insert(byte_toks.size(),
                         char_tok(mclex_pkg::KIND_OPER, op_char, 8'h00, 8'd1));
        op_held = 1'b0;
        op_char = 8'h00;
      end
    end
    if (byte_toks.size() > 0) byte_toks[byte_toks.size() - 1].last = 1'b1;
  endtask

  task automatic send_byte(input logic [7:0] c, input logic eoi);
    if (!calm && $urandom_range(0, 99) < 11) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= eoi;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    lex_byte(c, eoi);
  endtask

  task automatic send_predicted(input logic [7:0] c, input logic eoi);
    send_byte(c, eoi);
    foreach (byte_toks[i]) token_q.insert(token_q.size(), byte_toks[i]);
  endtask

  task automatic add_row(input logic [7:0] c, input logic eoi);
    stim_row_t r;
    r = '0;
    r.code = c;
    r.eoi  = eoi;
    directed_rows.insert(directed_rows.size(), r);
  endtask

  task automatic add_typed(input logic [7:0] c, input logic eoi, input logic [2:0] kind,
                           input logic [1:0] kwi, input logic [7:0] c1, input logic [7:0] c2,
                           input logic [7:0] len);
    stim_row_t r;
    r.code  = c;
    r.eoi   = eoi;
    r.typed = 1'b1;
    r.tok   = char_tok(kind, c1, c2, len);
    r.tok.kwi  = kwi;
    r.tok.last = 1'b1;
    directed_rows.insert(directed_rows.size(), r);
  endtask

  function automatic logic [7:0] rand_letter();
    return 8'("a" + $urandom_range(0, 25));
  endfunction

  task automatic make_piece();
    int    r;
    int    n;
    int    k;
    string w;
    piece.delete();
    r = $urandom_range(0, 99);
    if (r < 20) begin
      w = kw_words[$urandom_range(0, 3)];
      for (int i = 0; i < w.len(); i++) piece.insert(piece.size(), w[i]);
    end else if (r < 30) begin
      // near misses: cut short, one letter too many, one letter changed
      k = $urandom_range(0, 3);
      w = kw_words[k];
      n = $urandom_range(0, 2);
      for (int i = 0; i < kw_size[k] - ((n == 0) ? 1 : 0); i++) piece.insert(piece.size(), w[i]);
      if (n == 1) piece.insert(piece.size(), rand_letter());
      if (n == 2) piece[$urandom_range(0, piece.size() - 1)] = rand_letter();
    end else if (r < 45) begin
      piece.insert(piece.size(), ($urandom_range(0, 7) == 0) ? 8'("_") : rand_letter());
      n = $urandom_range(0, 5);
      for (int i = 0; i < n; i++)
        piece.insert(piece.size(),
                     $urandom_range(0, 1) ? rand_letter() : 8'("0" + $urandom_range(0, 9)));
    end else if (r < 60) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) piece.insert(piece.size(), 8'("0" + $urandom_range(0, 9)));
      k = $urandom_range(0, 3);
      if (k == 3) begin
        piece.delete();
        piece.insert(0, mclex_pkg::CH_DOT);
      end else begin
        if (k >= 1) piece.insert($urandom_range(0, piece.size()), mclex_pkg::CH_DOT);
        if (k == 2) piece.insert($urandom_range(0, piece.size()), mclex_pkg::CH_DOT);
      end
    end else if (r < 72) begin
      n = $urandom_range(0, 3);
      if (n <= 1) begin
        piece.insert(piece.size(), op_chars[$urandom_range(0, 6)]);
      end else begin
        w = $urandom_range(0, 1) ? "+" : "-";
        piece.insert(piece.size(), w[0]);
        piece.insert(piece.size(),
                     (n == 3 && $urandom_range(0, 1)) ? op_chars[$urandom_range(0, 6)] : w[0]);
        if (n == 3) piece.insert(piece.size(), w[0]);
      end
    end else if (r < 82) begin
      piece.insert(piece.size(), sym_chars[$urandom_range(0, 4)]);
    end else if (r < 92) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) piece.insert(piece.size(), 8'($urandom_range(0, 255)));
    end else begin
      piece.insert(piece.size(), ws_chars[$urandom_range(0, 5)]);
    end
    if ($urandom_range(0, 99) < 70) piece.insert(piece.size(), ws_chars[$urandom_range(0, 5)]);
    piece_eoi = ($urandom_range(0, 99) < 5);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // token beats are sampled on the falling edge, ahead of the rising edge that takes them
  always @(negedge clk) begin : token_check
    token_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (token_q.size() == 0) begin
        $error("token beat with nothing expected: tdata %h tuser %h tlast %b",
               out_tdata, out_tuser, out_tlast);
        errors++;
      end else begin
        want = token_q.pop_front();
        check_field("token_kind", 8'(want.kind), 8'(out_tuser));
        check_field("keyword_index", 8'(want.kwi), 8'(out_tdata[1:0]));
        check_field("first_char", want.c1, out_tdata[9:2]);
        check_field("second_char", want.c2, out_tdata[17:10]);
        check_field("token_length", want.len, out_tdata[25:18]);
        check_field("last_of_run", 8'(want.last), 8'(out_tlast));
      end
    end
  end

  initial begin : token_sink
    int held;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_tready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= calm || ($urandom_range(0, 99) >= 11);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : source_text
    int random_sent;
    logic hold_done;
    stim_row_t r;

    add_typed("(", 1'b0, mclex_pkg::KIND_SYMBOL, '0, "(", 8'h00, 8'd1);
    add_row("i", 1'b0);
    add_row("n", 1'b0);
    add_row("t", 1'b0);
    add_typed(" ", 1'b0, mclex_pkg::KIND_KEYWORD, mclex_pkg::KW_INT, 8'h00, 8'h00, 8'd3);
    add_row("x", 1'b0);
    add_row("+", 1'b0);
    add_typed("+", 1'b0, mclex_pkg::KIND_OPER, '0, mclex_pkg::CH_PLUS, mclex_pkg::CH_PLUS, 8'd2);
    add_row("-", 1'b0);
    add_typed("-", 1'b0, mclex_pkg::KIND_OPER, '0, mclex_pkg::CH_MINUS, mclex_pkg::CH_MINUS,
              8'd2);
    add_row(".", 1'b0);
    add_row(";", 1'b0);
    add_row("0", 1'b0);
    add_row(".", 1'b0);
    add_row("9", 1'b0);
    add_row("\r", 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row("=", 1'b0);
    add_typed("<", 1'b0, mclex_pkg::KIND_OPER, '0, "=", 8'h00, 8'd1);
    add_row(")", 1'b1);
    add_row("*", 1'b0);
    add_row("a", 1'b1);
    add_typed(">", 1'b1, mclex_pkg::KIND_OPER, '0, ">", 8'h00, 8'd1);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      send_byte(r.code, r.eoi);
      if (r.typed) token_q.insert(token_q.size(), r.tok);
      else foreach (byte_toks[j]) token_q.insert(token_q.size(), byte_toks[j]);
    end

    // sender pause until the token stream drains
    in_tvalid <= 1'b0;
    wait (token_q.size() == 0);
    @(posedge clk);

    random_sent = 0;
    hold_done = 1'b0;
    while (random_sent < RANDOM_BYTES) begin
      if (!hold_done && random_sent >= 40) begin
        rx_hold_req = 1'b1;
        hold_done = 1'b1;
      end
      calm = (random_sent >= 90 && random_sent < 130);
      make_piece();
      foreach (piece[i]) send_predicted(piece[i], piece_eoi && (i == piece.size() - 1));
      random_sent += piece.size();
    end
    calm = 1'b0;
    send_predicted(" ", 1'b1);
    in_tvalid <= 1'b0;

    wait (token_q.size() == 0);
    repeat (12) @(posedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
